// ===== hdl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk_i while out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequent in the same cycle.
`define ASSERT_IMPL(label, cond, cons, msg) \
  `ASSERT_CLK(label, (cond) |-> (cons), msg)

`endif

// ===== hdl/brfp_pkg.sv =====
package brfp_pkg;

  // Payload store depth
  localparam int unsigned MaxPayload = 64;

  // Configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgStartMarker  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEndMarker    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRegisterLow  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRegisterHigh = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgErrorStatus  = 3'd4;

  localparam logic [7:0] StartMarkerRst  = 8'd221;
  localparam logic [7:0] EndMarkerRst    = 8'd119;
  localparam logic [7:0] RegisterLowRst  = 8'd3;
  localparam logic [7:0] RegisterHighRst = 8'd255;
  localparam logic [7:0] ErrorStatusRst  = 8'd128;

  // Register code that a write acknowledge carries
  localparam logic [7:0] WriteAckReg = 8'd1;

  // Status byte of a good response
  localparam logic [7:0] StatusOk = 8'd0;

  // Checksum seed, 0x10000 in a 17-bit accumulator
  localparam logic [16:0] CksSeed = 17'h10000;

  localparam bit CmdReceive = 1'b0;
  localparam bit CmdArmWait = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic arm_pending;
    logic clr_pending;
    logic start_frame;
    logic cap_reg;
    logic cap_len;
    logic store_byte;
    logic emit_start;
    logic emit_read;
    logic emit_load;
    logic emit_advance;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic reg_in_range;
    logic is_write_ack;
    logic write_pending;
    logic status_ok;
    logic len_too_big;
    logic fill_ok;
    logic fill_last;
    logic ckhi_match;
    logic cklo_match;
    logic emit_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/brfp_ctrl.sv =====
module brfp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              command_i,
  input  logic              timed_out_i,
  input  brfp_pkg::dp_sts_t sts_i,
  output logic              in_ready_o,
  output brfp_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_REG    = 11'b000_0000_0010,
    S_STATUS = 11'b000_0000_0100,
    S_LEN    = 11'b000_0000_1000,
    S_DATA   = 11'b000_0001_0000,
    S_CKHI   = 11'b000_0010_0000,
    S_CKLO   = 11'b000_0100_0000,
    S_END    = 11'b000_1000_0000,
    S_WAIT   = 11'b001_0000_0000,
    S_RD     = 11'b010_0000_0000,
    S_LD     = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   emitting;
  logic   rx_beat;

  assign emitting   = (state_q == S_RD) || (state_q == S_LD);
  assign in_ready_o = !emitting;
  assign rx_beat    = in_valid_i && in_ready_o && (command_i == brfp_pkg::CmdReceive);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.arm_pending = in_valid_i && in_ready_o && (command_i == brfp_pkg::CmdArmWait);
    unique case (state_q)
      S_IDLE: begin
        if (rx_beat && sts_i.is_start) begin
          cmd_o.start_frame = 1'b1;
          state_d = S_REG;
        end
      end
      S_REG: begin
        if (rx_beat) begin
          if (sts_i.reg_in_range) begin
            cmd_o.cap_reg = 1'b1;
            state_d = S_STATUS;
          end else if (sts_i.is_write_ack && sts_i.write_pending) begin
            state_d = S_WAIT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_STATUS: begin
        if (rx_beat) state_d = sts_i.status_ok ? S_LEN : S_IDLE;
      end
      S_LEN: begin
        if (rx_beat) begin
          cmd_o.cap_len = 1'b1;
          state_d = sts_i.len_too_big ? S_IDLE : S_DATA;
        end
      end
      S_DATA: begin
        if (rx_beat) begin
          if (sts_i.fill_ok) begin
            cmd_o.store_byte = 1'b1;
            if (sts_i.fill_last) state_d = S_CKHI;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_CKHI: begin
        if (rx_beat) state_d = sts_i.ckhi_match ? S_CKLO : S_IDLE;
      end
      S_CKLO: begin
        if (rx_beat) state_d = sts_i.cklo_match ? S_END : S_IDLE;
      end
      S_END: begin
        if (rx_beat && sts_i.is_end) begin
          cmd_o.emit_start = 1'b1;
          state_d = S_RD;
        end
      end
      S_WAIT: begin
        if (rx_beat && (sts_i.is_end || timed_out_i)) begin
          cmd_o.clr_pending = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.emit_read = 1'b1;
        state_d = S_LD;
      end
      S_LD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.emit_advance = 1'b1;
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/brfp_dpath.sv =====
module brfp_dpath #(
  parameter int unsigned MAX_PAYLOAD = brfp_pkg::MaxPayload
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brfp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_wdata_i,
  input  logic [7:0]                    rx_byte_i,
  input  brfp_pkg::dp_cmd_t             cmd_i,
  output brfp_pkg::dp_sts_t             sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [7:0]                    reg_code_o,
  output logic [7:0]                    payload_byte_o,
  output logic [5:0]                    byte_index_o,
  output logic                          last_o
);

  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned IdxW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]      start_marker_q, end_marker_q, register_low_q, register_high_q;
  logic            write_pending_q;
  logic [7:0]      frame_reg_q;
  logic [CntW-1:0] len_q;
  logic [CntW-1:0] fill_q;
  logic [16:0]     cks_q;
  logic [IdxW-1:0] emit_k_q;
  logic [7:0]      rd_data_q;
  logic [7:0]      payload_mem [MAX_PAYLOAD];

  logic            out_valid_q;
  logic [7:0]      reg_code_q, payload_q;
  logic [5:0]      index_q;
  logic            last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q  <= brfp_pkg::StartMarkerRst;
      end_marker_q    <= brfp_pkg::EndMarkerRst;
      register_low_q  <= brfp_pkg::RegisterLowRst;
      register_high_q <= brfp_pkg::RegisterHighRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        brfp_pkg::CfgStartMarker:  start_marker_q  <= cfg_wdata_i;
        brfp_pkg::CfgEndMarker:    end_marker_q    <= cfg_wdata_i;
        brfp_pkg::CfgRegisterLow:  register_low_q  <= cfg_wdata_i;
        brfp_pkg::CfgRegisterHigh: register_high_q <= cfg_wdata_i;
        // error status: every nonzero status drops the frame, nothing to hold
        brfp_pkg::CfgErrorStatus:  ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_pending_q <= 1'b0;
    end else if (cmd_i.arm_pending) begin
      write_pending_q <= 1'b1;
    end else if (cmd_i.clr_pending) begin
      write_pending_q <= 1'b0;
    end
  end

  // Frame registers and running checksum
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_frame) cks_q <= brfp_pkg::CksSeed;
    if (cmd_i.cap_reg) frame_reg_q <= rx_byte_i;
    if (cmd_i.cap_len) begin
      len_q  <= CntW'(rx_byte_i);
      fill_q <= '0;
      cks_q  <= cks_q - {9'd0, rx_byte_i};
    end
    if (cmd_i.store_byte) begin
      fill_q <= fill_q + CntW'(1);
      cks_q  <= cks_q - {9'd0, rx_byte_i};
    end
  end

  // Payload store
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) payload_mem[fill_q[IdxW-1:0]] <= rx_byte_i;
    if (cmd_i.emit_read) rd_data_q <= payload_mem[emit_k_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_start) begin
      emit_k_q <= '0;
    end else if (cmd_i.emit_advance) begin
      emit_k_q <= emit_k_q + IdxW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      reg_code_q <= frame_reg_q;
      payload_q  <= rd_data_q;
      index_q    <= 6'(emit_k_q);
      last_q     <= sts_o.emit_last;
    end
  end

  always_comb begin
    sts_o.is_start      = (rx_byte_i == start_marker_q);
    sts_o.is_end        = (rx_byte_i == end_marker_q);
    sts_o.reg_in_range  = (rx_byte_i >= register_low_q) && (rx_byte_i <= register_high_q);
    sts_o.is_write_ack  = (rx_byte_i == brfp_pkg::WriteAckReg);
    sts_o.write_pending = write_pending_q;
    sts_o.status_ok     = (rx_byte_i == brfp_pkg::StatusOk);
    sts_o.len_too_big   = (rx_byte_i > 8'(MAX_PAYLOAD));
    sts_o.fill_ok       = (fill_q < len_q);
    sts_o.fill_last     = ((fill_q + CntW'(1)) == len_q);
    sts_o.ckhi_match    = (rx_byte_i == cks_q[15:8]);
    sts_o.cklo_match    = (rx_byte_i == cks_q[7:0]);
    sts_o.emit_last     = ((CntW'(emit_k_q) + CntW'(1)) == len_q);
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign reg_code_o     = reg_code_q;
  assign payload_byte_o = payload_q;
  assign byte_index_o   = index_q;
  assign last_o         = last_q;

endmodule

// ===== hdl/bms_response_frame_parser.sv =====
// Battery-monitor response frame parser. Each input beat carries either one
// received UART byte (command 0) or an arm request for the write-acknowledge
// wait (command 1). A frame is start byte, register code within
// [register_low, register_high], status byte (must be zero, any other value
// drops the frame), length byte (at most MAX_PAYLOAD), the payload, checksum
// high and low bytes (0x10000 minus length and payload) and the end
// byte. Bad frames are dropped without notice. After a good end byte the
// block emits one output beat per payload byte, carrying the register code
// and the byte index, with last set on the final byte. Byte beats are
// accepted back to back; after the end byte the input stalls while the
// frame drains, each payload byte taking a registered read of the payload
// memory and then a load of the output register, and the drain pauses when
// out_ready_i is held low. The last result may wait in the output register
// while the next byte is already accepted. The payload memory needs no
// clearing after reset: only entries written in the current frame are read.
module bms_response_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = brfp_pkg::MaxPayload
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [brfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_wdata_i,
  // input beats
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         timed_out_i,
  // output beats
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   reg_code_o,
  output logic [7:0]                   payload_byte_o,
  output logic [5:0]                   byte_index_o,
  output logic                         last_o
);

  `include "assert_macros.svh"

  brfp_pkg::dp_cmd_t cmd;
  brfp_pkg::dp_sts_t sts;
  logic              in_beat;

  assign in_beat = in_valid_i && in_ready_o;

  // Frame phase sequencing and drain control
  brfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .timed_out_i (timed_out_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  // Config, checksum, payload memory and output register
  brfp_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rx_byte_i      (rx_byte_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .reg_code_o     (reg_code_o),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .last_o         (last_o)
  );

  // Drain starts only on an accepted beat (the end byte).
  `ASSERT_CLK(a_drain_after_beat, $fell(in_ready_o) |-> $past(in_beat), "drain without beat")
  // A result is only loaded while draining.
  `ASSERT_CLK(a_load_in_drain, $rose(out_valid_o) |-> $past(!in_ready_o), "load outside drain")
  // Input reopens exactly when the final byte of the frame was loaded.
  `ASSERT_IMPL(a_reopen_on_last, $rose(in_ready_o), out_valid_o && last_o, "reopen before last")

endmodule

// ===== verif/bms_response_frame_parser_checker.sv =====
`timescale 1ns / 100ps

module bms_response_frame_parser_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [brfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         command_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         timed_out_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [7:0]                   reg_code_i,
  input  logic [7:0]                   payload_byte_i,
  input  logic [5:0]                   byte_index_i,
  input  logic                         last_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import brfp_pkg::*;

  typedef enum logic [3:0] {
    ParseIdle,
    ParseReg,
    ParseStatus,
    ParseLen,
    ParseData,
    ParseCksHi,
    ParseCksLo,
    ParseEnd,
    ParseAckWait
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] reg_code;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last;
  } payload_beat_t;

  logic [7:0]    start_marker, end_marker, reg_low, reg_high, error_status;
  parse_phase_e  phase;
  logic [7:0]    frame_reg, frame_len, fill_idx;
  logic [16:0]   cks;
  logic [7:0]    payload_mem [MaxPayload];
  logic          ack_pending;
  payload_beat_t payload_beat_q [$];
  int unsigned   fails;

  task automatic clear_parser();
    start_marker = StartMarkerRst;
    end_marker   = EndMarkerRst;
    reg_low      = RegisterLowRst;
    reg_high     = RegisterHighRst;
    error_status = ErrorStatusRst;
    phase        = ParseIdle;
    frame_reg    = '0;
    frame_len    = '0;
    fill_idx     = '0;
    cks          = '0;
    ack_pending  = 1'b0;
    fails        = 0;
    payload_beat_q.delete();
  endtask

  // Advance the parser by one input beat and queue the payload beats it releases.
  task automatic parse_byte(input logic cmd, input logic [7:0] b, input logic tmo);
    payload_beat_t beat;
    if (cmd == CmdArmWait) begin
      ack_pending = 1'b1;
      return;
    end
    case (phase)
      ParseIdle: begin
        if (b == start_marker) begin
          phase = ParseReg;
          cks   = CksSeed;
        end
      end
      ParseReg: begin
        if (b >= reg_low && b <= reg_high) begin
          frame_reg = b;
          phase     = ParseStatus;
        end else if (b == WriteAckReg && ack_pending) begin
          phase = ParseAckWait;
        end else begin
          phase = ParseIdle;
        end
      end
      ParseStatus: phase = (b == StatusOk) ? ParseLen : ParseIdle;
      ParseLen: begin
        frame_len = b;
        fill_idx  = '0;
        cks       = cks - 17'(b);
        phase     = (int'(b) > MaxPayload) ? ParseIdle : ParseData;
      end
      ParseData: begin
        if (fill_idx < frame_len && int'(fill_idx) < MaxPayload) begin
          payload_mem[fill_idx] = b;
          cks      = cks - 17'(b);
          fill_idx = fill_idx + 8'd1;
          if (fill_idx == frame_len) phase = ParseCksHi;
        end else begin
          // zero-length frame: drop this byte and give up
          phase = ParseIdle;
        end
      end
      ParseCksHi: phase = (b == cks[15:8]) ? ParseCksLo : ParseIdle;
      ParseCksLo: phase = (b == cks[7:0]) ? ParseEnd : ParseIdle;
      ParseEnd: begin
        if (b == end_marker) begin
          for (int k = 0; k < int'(frame_len) && k < MaxPayload; k++) begin
            beat.reg_code     = frame_reg;
            beat.payload_byte = payload_mem[k];
            beat.byte_index   = 6'(k);
            beat.last         = (k + 1 == int'(frame_len));
            payload_beat_q.push_back(beat);
          end
          cks   = '0;
          phase = ParseIdle;
        end
      end
      ParseAckWait: begin
        if (b == end_marker || tmo) begin
          phase       = ParseIdle;
          ack_pending = 1'b0;
        end
      end
      default: phase = ParseIdle;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic check_payload_beat();
    payload_beat_t want;
    if (payload_beat_q.size() == 0) begin
      $error("unexpected output beat: reg_code %0d payload_byte %0d byte_index %0d last %0d",
             reg_code_i, payload_byte_i, byte_index_i, last_i);
      fails++;
      return;
    end
    want = payload_beat_q.pop_front();
    check_field("reg_code", 32'(want.reg_code), 32'(reg_code_i));
    check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte_i));
    check_field("byte_index", 32'(want.byte_index), 32'(byte_index_i));
    check_field("last", 32'(want.last), 32'(last_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgStartMarker:  start_marker = cfg_wdata_i;
          CfgEndMarker:    end_marker   = cfg_wdata_i;
          CfgRegisterLow:  reg_low      = cfg_wdata_i;
          CfgRegisterHigh: reg_high     = cfg_wdata_i;
          CfgErrorStatus:  error_status = cfg_wdata_i;
          default: ;
        endcase
      end
      // retire the older output beat before new input can queue more
      if (out_valid_i && out_ready_i) check_payload_beat();
      if (in_valid_i && in_ready_i) parse_byte(command_i, rx_byte_i, timed_out_i);
      fail_count_o <= fails;
      pending_o    <= payload_beat_q.size();
    end
  end

endmodule

// ===== verif/bms_response_frame_parser_tb.sv =====
`timescale 1ns / 100ps

module bms_response_frame_parser_tb;
  import brfp_pkg::*;

  // Cycles with no beat on either channel before the run is declared hung
  localparam int unsigned WatchdogLimit  = 2000;
  // Spare cycles after the last payload beat has drained
  localparam int unsigned SettleCycles   = 8;
  // Frame beats per configuration phase, five phases in all
  localparam int unsigned PhaseBeats     = 70;

  typedef enum {
    FrameGood,
    FrameBadCks,
    FrameBadStatus,
    FrameZeroLen,
    FrameTooLong,
    FrameStrayEnd,
    FrameAck
  } frame_kind_e;

  logic                clk, rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [7:0]          cfg_wdata;
  logic                in_valid, in_ready_o;
  logic                command, timed_out;
  logic [7:0]          rx_byte;
  logic                out_valid_o, out_ready;
  logic [7:0]          reg_code_o, payload_byte_o;
  logic [5:0]          byte_index_o;
  logic                last_o;
  int unsigned         fail_count, pending_beats;

  // Stimulus copy of the configuration, used to build frames
  logic [7:0]          cfg_start, cfg_end, cfg_low, cfg_high, cfg_err;
  // Frame beats sent so far; noise beats are left out
  int unsigned         frame_beats;
  // Suppress all idling on both channels while set
  bit                  burst_mode;

  bms_response_frame_parser i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .command_i      (command),
    .rx_byte_i      (rx_byte),
    .timed_out_i    (timed_out),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .reg_code_o     (reg_code_o),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .last_o         (last_o)
  );

  bms_response_frame_parser_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready_o),
    .command_i      (command),
    .rx_byte_i      (rx_byte),
    .timed_out_i    (timed_out),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready),
    .reg_code_i     (reg_code_o),
    .payload_byte_i (payload_byte_o),
    .byte_index_i   (byte_index_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic rand_timeout();
    return ($urandom_range(0, 9) == 0);
  endfunction

  // Pick a register code inside the accepted range; an empty range gives any code.
  function automatic logic [7:0] pick_reg();
    if (cfg_low <= cfg_high) return 8'($urandom_range(cfg_low, cfg_high));
    return 8'($urandom);
  endfunction

  // Keep most frames short so the drain stays cheap; reach the full store rarely.
  function automatic logic [7:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(1, 8));
    if (r < 95) return 8'($urandom_range(9, 32));
    if (r < 98) return 8'(MaxPayload);
    return 8'($urandom_range(33, MaxPayload));
  endfunction

  // Present one input beat and hold it until accepted. Lower valid only across a
  // real gap, so valid never drops and rises within one time step.
  task automatic send_beat(input logic cmd, input logic [7:0] b, input logic tmo);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    rx_byte   <= b;
    timed_out <= tmo;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
  endtask

  // Drop valid, wait for every payload beat to drain, then allow spare cycles.
  task automatic wait_settled();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write all five registers back to back; call only while the block is idle.
  task automatic write_regs(input logic [7:0] s, e, lo, hi, err);
    cfg_we    <= 1'b1;
    cfg_index <= CfgStartMarker;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= CfgEndMarker;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_index <= CfgRegisterLow;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CfgRegisterHigh;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= CfgErrorStatus;
    cfg_wdata <= err;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_start = s;
    cfg_end   = e;
    cfg_low   = lo;
    cfg_high  = hi;
    cfg_err   = err;
  endtask

  // Build one frame of the given kind as {timeout, byte} beats and send it.
  task automatic send_frame(input frame_kind_e kind);
    logic [8:0]  seq [$];
    logic [16:0] cks;
    logic [7:0]  len, b, status;
    cks = CksSeed;
    if (kind == FrameAck) begin
      // arm the wait, then a write acknowledge closed by end byte or timeout
      send_beat(CmdArmWait, 8'($urandom), 1'($urandom));
      seq.push_back({1'b0, cfg_start});
      seq.push_back({1'b0, WriteAckReg});
      repeat ($urandom_range(0, 4)) seq.push_back({1'b0, 8'($urandom)});
      if ($urandom_range(0, 1) == 1) seq.push_back({1'b0, cfg_end});
      else seq.push_back({1'b1, 8'($urandom)});
    end else begin
      seq.push_back({rand_timeout(), cfg_start});
      seq.push_back({rand_timeout(), pick_reg()});
      if (kind == FrameBadStatus) begin
        status = ($urandom_range(0, 1) == 1) ? cfg_err : 8'($urandom_range(1, 255));
        if (status == StatusOk) status = ~StatusOk;
        seq.push_back({rand_timeout(), status});
      end else begin
        seq.push_back({rand_timeout(), StatusOk});
        case (kind)
          FrameZeroLen: len = 8'd0;
          FrameTooLong: len = 8'($urandom_range(MaxPayload + 1, 255));
          default:      len = pick_len();
        endcase
        seq.push_back({rand_timeout(), len});
        cks = cks - 17'(len);
        if (kind == FrameZeroLen) begin
          seq.push_back({rand_timeout(), 8'($urandom)});
        end else if (kind != FrameTooLong) begin
          repeat (len) begin
            b   = 8'($urandom);
            cks = cks - 17'(b);
            seq.push_back({rand_timeout(), b});
          end
          if (kind == FrameBadCks) begin
            int unsigned bit_sel;
            bit_sel = $urandom_range(0, 15);
            cks[bit_sel] = ~cks[bit_sel];
          end
          seq.push_back({rand_timeout(), cks[15:8]});
          seq.push_back({rand_timeout(), cks[7:0]});
          if (kind == FrameStrayEnd) begin
            repeat ($urandom_range(1, 2)) begin
              b = 8'($urandom);
              if (b == cfg_end) b = ~b;
              seq.push_back({rand_timeout(), b});
            end
          end
          seq.push_back({rand_timeout(), cfg_end});
        end
      end
    end
    frame_beats += seq.size();
    foreach (seq[i]) send_beat(CmdReceive, seq[i][7:0], seq[i][8]);
  endtask

  // Mostly well-formed frames with random content, the rest broken frames and noise.
  task automatic run_random(input int unsigned beats);
    int unsigned goal, r;
    goal = frame_beats + beats;
    while (frame_beats < goal) begin
      burst_mode = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 6))
          send_beat(($urandom_range(0, 7) == 0) ? CmdArmWait : CmdReceive,
                    8'($urandom), 1'($urandom));
      end
      else if (r < 16) send_frame(FrameAck);
      else if (r < 66) send_frame(FrameGood);
      else if (r < 72) send_frame(FrameBadCks);
      else if (r < 78) send_frame(FrameBadStatus);
      else if (r < 84) send_frame(FrameZeroLen);
      else if (r < 90) send_frame(FrameTooLong);
      else send_frame(FrameStrayEnd);
    end
    burst_mode = 1'b0;
  endtask

  // Output side: random stalls, then a run of ready cycles.
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int unsigned stall;
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog: end the run when neither channel moves a beat for too long.
  initial begin : watchdog
    int unsigned still_cycles;
    still_cycles = 0;
    while (still_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) still_cycles = 0;
      else still_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CfgStartMarker;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    command     <= CmdReceive;
    rx_byte     <= '0;
    timed_out   <= 1'b0;
    cfg_start   = StartMarkerRst;
    cfg_end     = EndMarkerRst;
    cfg_low     = RegisterLowRst;
    cfg_high    = RegisterHighRst;
    cfg_err     = ErrorStatusRst;
    frame_beats = 0;
    burst_mode  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset configuration.
    // Arm with every other field at its high end; the arm ignores them.
    send_beat(CmdArmWait, 8'hFF, 1'b1);
    // Write acknowledge: a zero byte holds the wait, the end byte leaves it.
    send_beat(CmdReceive, cfg_start, 1'b0);
    send_beat(CmdReceive, WriteAckReg, 1'b0);
    send_beat(CmdReceive, 8'h00, 1'b0);
    send_beat(CmdReceive, cfg_end, 1'b0);
    // Write acknowledge left through the timeout.
    send_beat(CmdArmWait, 8'h00, 1'b0);
    send_beat(CmdReceive, cfg_start, 1'b0);
    send_beat(CmdReceive, WriteAckReg, 1'b0);
    send_beat(CmdReceive, 8'h00, 1'b1);
    // Good one-byte frame carrying 0xFF, checksum 0xFF00, with a timeout outside
    // the wait and a stray byte ahead of the end byte.
    send_beat(CmdReceive, cfg_start, 1'b1);
    send_beat(CmdReceive, RegisterLowRst, 1'b0);
    send_beat(CmdReceive, StatusOk, 1'b0);
    send_beat(CmdReceive, 8'd1, 1'b0);
    send_beat(CmdReceive, 8'hFF, 1'b0);
    send_beat(CmdReceive, 8'hFF, 1'b1);
    send_beat(CmdReceive, 8'h00, 1'b0);
    send_beat(CmdReceive, 8'h00, 1'b0);
    send_beat(CmdReceive, cfg_end, 1'b0);
    // Zero length: the next byte is swallowed.
    send_beat(CmdReceive, cfg_start, 1'b0);
    send_beat(CmdReceive, RegisterLowRst, 1'b0);
    send_beat(CmdReceive, StatusOk, 1'b0);
    send_beat(CmdReceive, 8'd0, 1'b0);
    send_beat(CmdReceive, 8'h55, 1'b0);
    // Device error status drops the frame.
    send_beat(CmdReceive, cfg_start, 1'b0);
    send_beat(CmdReceive, RegisterLowRst, 1'b0);
    send_beat(CmdReceive, cfg_err, 1'b0);
    // Length one past the store drops the frame.
    send_beat(CmdReceive, cfg_start, 1'b0);
    send_beat(CmdReceive, RegisterLowRst, 1'b0);
    send_beat(CmdReceive, StatusOk, 1'b0);
    send_beat(CmdReceive, 8'(MaxPayload + 1), 1'b0);

    run_random(PhaseBeats);

    // Extremes: a single accepted code 0, so code 1 always means acknowledge.
    wait_settled();
    write_regs(8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF);
    run_random(PhaseBeats);

    // Extremes flipped: full range, code 1 is an ordinary register.
    wait_settled();
    write_regs(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00);
    run_random(PhaseBeats);

    // Random markers and a random range, possibly empty.
    wait_settled();
    write_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random(PhaseBeats);

    // Random markers with code 1 at the bottom of the range.
    wait_settled();
    write_regs(8'($urandom), 8'($urandom), WriteAckReg, 8'($urandom_range(1, 255)),
               8'($urandom));
    run_random(PhaseBeats);

    wait_settled();
    if (fail_count == 0 && pending_beats == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
